>>> design/staircase_light_timer_with_warning_unit_macros.svh
// Assertion helpers shared by the timer RTL.
`ifndef STAIRCASE_LIGHT_TIMER_WITH_WARNING_UNIT_MACROS_SVH
`define STAIRCASE_LIGHT_TIMER_WITH_WARNING_UNIT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define SLTW_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence.
`define SLTW_ASSERT_2CYC(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig) |-> ##2 (cons)) else $error(msg);

`endif

>>> design/sltw_pkg.sv
`default_nettype none

package sltw_pkg;

    typedef enum logic [2:0] {
        OP_MS_TICK   = 3'd0,
        OP_BLINK     = 3'd1,
        OP_TOGGLE    = 3'd2,
        OP_RETRIGGER = 3'd3,
        OP_MINUS     = 3'd4,
        OP_PLUS      = 3'd5,
        OP_SAMPLE    = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        CFG_MIN_ON_TIME = 2'd0,
        CFG_SPAN        = 2'd1,
        CFG_ADJUST_STEP = 2'd2
    } t_cfg_idx;

    localparam logic [14:0] MIN_ON_TIME_RST = 15'd8400;
    localparam logic [14:0] SPAN_RST        = 15'd6000;
    localparam logic [9:0]  ADJUST_STEP_RST = 10'd100;
    localparam logic [15:0] ON_TIME_RST     = 16'd11400;
    localparam logic [14:0] OFF_DELAY_RST   = 15'd3800;
    localparam logic [16:0] ELAPSED_MAX     = 17'd131071;

    // Reciprocal of 3 for a 16-bit dividend: (x * RECIP3) >> 17.
    localparam logic [16:0] RECIP3 = 17'h0AAAB;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] pot_sample;
    } t_in;

    typedef struct packed {
        logic               lamp;
        logic               warning_lamp;
        logic [15:0]        on_time_now;
        logic signed [15:0] extension_now;
    } t_out;

endpackage

`default_nettype wire

>>> design/staircase_light_timer_with_warning_unit.sv
// Staircase light timer with prewarning. Each input transaction is one event (millisecond
// tick, blink tick, toggle, retrigger, minus, plus or potentiometer sample) and yields one
// result transaction with the lamp, the warning lamp, the on-time and the extension as they
// stand after that event. Every event except a sample passes through an input register and
// one stage of update logic, so one transaction per cycle is sustained while the output is
// taken. A sample runs through a four-stage arithmetic pipeline (multiply by the span, divide
// by 255, add the minimum, divide by 3); the block holds off further input until the
// sample's result leaves the pipeline. Configuration writes are taken in any cycle; a new
// minimum or span is applied at the next sample.
`default_nettype none

`include "staircase_light_timer_with_warning_unit_macros.svh"

module staircase_light_timer_with_warning_unit
    import sltw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in      i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out          o_out_data,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);

    // Configuration
    logic [14:0] r_min_on;
    logic [14:0] r_span;
    logic [9:0]  r_step;

    // Timer state
    logic               r_lamp_on, n_lamp_on;
    logic               r_warn_en, n_warn_en;
    logic               r_warn_lvl, n_warn_lvl;
    logic [16:0]        r_elapsed, n_elapsed;
    logic [15:0]        r_on_time, n_on_time;
    logic [14:0]        r_off_delay, n_off_delay;
    logic signed [15:0] r_ext, n_ext;

    // Input and output registers
    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;

    // Sample pipeline
    logic [3:0]  r_smp_vld;
    logic [22:0] r_prod;
    logic [15:0] r_qest;
    logic [15:0] r_smp_ont;
    logic [32:0] r_mul3;

    logic out_free;
    logic item_ok;
    logic consume;
    logic smp_start;

    logic [23:0]        qsum;
    logic [23:0]        rem;
    logic [15:0]        q_fix;
    logic signed [18:0] limit;
    logic signed [18:0] elapsed_s;
    logic signed [17:0] ext_wide;

    assign out_free  = !r_out_vld || i_out_ready;
    assign item_ok   = (r_in.operation != OP_SAMPLE) || r_smp_vld[3];
    assign consume   = r_in_vld && item_ok && out_free;
    assign smp_start = r_in_vld && (r_in.operation == OP_SAMPLE) && (r_smp_vld == 4'd0);

    assign o_in_ready  = !r_in_vld || consume;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Quotient estimate for p / 255 using 1/255 = 1/256 + 1/65536 + ...; it falls short by
    // at most a few counts, which the remainder compares put right.
    assign qsum  = {1'b0, r_prod} + {9'd0, r_prod[22:8]} + {17'd0, r_prod[22:16]};
    assign rem   = {1'b0, r_prod} - ({r_qest, 8'd0} - {8'd0, r_qest});
    assign q_fix = r_qest + 16'(rem >= 24'd255) + 16'(rem >= 24'd510) + 16'(rem >= 24'd765);

    assign limit     = $signed({3'b000, r_on_time}) + $signed({4'b0000, r_off_delay})
                     + $signed({{3{r_ext[15]}}, r_ext});
    assign elapsed_s = $signed({2'b00, r_elapsed});

    always_comb begin
        n_lamp_on   = r_lamp_on;
        n_warn_en   = r_warn_en;
        n_warn_lvl  = r_warn_lvl;
        n_elapsed   = r_elapsed;
        n_on_time   = r_on_time;
        n_off_delay = r_off_delay;
        n_ext       = r_ext;
        ext_wide    = $signed({{2{r_ext[15]}}, r_ext});
        case (r_in.operation)
            OP_MS_TICK: begin
                if (r_lamp_on) begin
                    n_warn_en = (r_elapsed >= {1'b0, r_on_time});
                    if (elapsed_s >= limit) begin
                        n_lamp_on  = 1'b0;
                        n_warn_en  = 1'b0;
                        n_warn_lvl = 1'b0;
                        n_elapsed  = '0;
                    end else if (r_elapsed < ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 17'd1;
                    end
                end
            end
            OP_BLINK: begin
                n_warn_lvl = r_warn_en ? !r_warn_lvl : 1'b0;
            end
            OP_TOGGLE: begin
                n_lamp_on = !r_lamp_on;
                n_elapsed = '0;
                if (r_lamp_on) begin
                    n_warn_en  = 1'b0;
                    n_warn_lvl = 1'b0;
                end
            end
            OP_RETRIGGER: begin
                if (r_lamp_on) begin
                    n_elapsed = '0;
                end
            end
            OP_MINUS, OP_PLUS: begin
                if (r_in.operation == OP_PLUS) begin
                    ext_wide = ext_wide + $signed({8'd0, r_step});
                end else begin
                    ext_wide = ext_wide - $signed({8'd0, r_step});
                end
                if (ext_wide > 18'sd32767) begin
                    n_ext = 16'sh7FFF;
                end else if (ext_wide < -18'sd32768) begin
                    n_ext = 16'sh8000;
                end else begin
                    n_ext = ext_wide[15:0];
                end
            end
            OP_SAMPLE: begin
                n_on_time   = r_smp_ont;
                n_off_delay = r_mul3[31:17];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_on    <= MIN_ON_TIME_RST;
            r_span      <= SPAN_RST;
            r_step      <= ADJUST_STEP_RST;
            r_lamp_on   <= 1'b0;
            r_warn_en   <= 1'b0;
            r_warn_lvl  <= 1'b0;
            r_elapsed   <= '0;
            r_on_time   <= ON_TIME_RST;
            r_off_delay <= OFF_DELAY_RST;
            r_ext       <= '0;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_smp_vld   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_ON_TIME: r_min_on <= i_cfg_data;
                    CFG_SPAN:        r_span   <= i_cfg_data;
                    CFG_ADJUST_STEP: r_step   <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end

            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end

            if (consume) begin
                r_lamp_on   <= n_lamp_on;
                r_warn_en   <= n_warn_en;
                r_warn_lvl  <= n_warn_lvl;
                r_elapsed   <= n_elapsed;
                r_on_time   <= n_on_time;
                r_off_delay <= n_off_delay;
                r_ext       <= n_ext;
                r_out_vld   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            // One sample in flight at a time; the last stage waits until its result is taken.
            r_smp_vld[0] <= smp_start;
            r_smp_vld[1] <= r_smp_vld[0];
            r_smp_vld[2] <= r_smp_vld[1];
            r_smp_vld[3] <= r_smp_vld[2] || (r_smp_vld[3] && !consume);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (consume) begin
            r_out.lamp          <= n_lamp_on;
            r_out.warning_lamp  <= n_warn_lvl;
            r_out.on_time_now   <= n_on_time;
            r_out.extension_now <= n_ext;
        end
        if (smp_start) begin
            r_prod <= 23'(r_in.pot_sample) * 23'(r_span);
        end
        if (r_smp_vld[0]) begin
            r_qest <= qsum[23:8];
        end
        if (r_smp_vld[1]) begin
            r_smp_ont <= 16'(q_fix + {1'b0, r_min_on});
        end
        if (r_smp_vld[2]) begin
            r_mul3 <= 33'(r_smp_ont) * 33'(RECIP3);
        end
    end

    `SLTW_ASSERT(a_smp_single, i_clk, i_rst_n, $onehot0(r_smp_vld),
        "more than one sample in the arithmetic pipeline")

    `SLTW_ASSERT(a_lamp_off_clean, i_clk, i_rst_n,
        !r_lamp_on |-> (!r_warn_en && !r_warn_lvl && (r_elapsed == 17'd0)),
        "warning or count active while the lamp is off")

    `SLTW_ASSERT(a_off_delay_third, i_clk, i_rst_n,
        ((18'(r_off_delay) * 18'd3) <= 18'(r_on_time)),
        "warning delay exceeds a third of the on-time")

    `SLTW_ASSERT_2CYC(a_smp_launch, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && (i_in_data.operation == OP_SAMPLE)), r_smp_vld[0],
        "accepted sample did not enter the arithmetic pipeline")

endmodule

`default_nettype wire
